// File: sv/mrq_pkg.sv
// Package for the message ring queue: sizes, codes and item types.
// Used by message_ring_queue_top and the testbench; depends on nothing else.
package mrq_pkg;

  localparam int SLOT_DEPTH  = 16;
  localparam int SLOT_BYTES  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int LEN_CAP     = (SLOT_BYTES < MAX_RESULTS) ? SLOT_BYTES : MAX_RESULTS;

  localparam int SLOT_IW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int BYTE_IW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int ADDR_W  = (SLOT_DEPTH * SLOT_BYTES > 1) ?
                           $clog2(SLOT_DEPTH * SLOT_BYTES) : 1;
  localparam int CNT_W   = 5;
  localparam int LEN_W   = 5;
  localparam int CFG_IW  = 1;

  localparam logic [2:0] KIND_PUT_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUT_FRONT = 3'd1;
  localparam logic [2:0] KIND_GET       = 3'd2;
  localparam logic [2:0] KIND_CLEAR     = 3'd3;
  localparam logic [2:0] KIND_TEST      = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_ENTRY_SIZE  = 1'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [4:0] max_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [4:0] copied_length;
    logic       not_empty;
  } out_item_t;

endpackage

// File: sv/mrq_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Used by message_ring_queue_top for message bytes and message lengths.
module mrq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/message_ring_queue_top.sv
// Top level of the message ring queue: control, pointers and registered results.
// Depends on mrq_pkg and on mrq_ram for the byte and length memories.
//
//   channel   ports                               handshake
//   input     start, busy, in_item                start && !busy
//   result    out_strobe, out_item                out_strobe, one cycle each
//   config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//             cfg_data
//
// Put, clear, test and a get on an empty ring leave busy low, and the result
// appears in the next cycle. A get of a non-empty ring holds busy in S_GLEN, which
// reads the length memory, then S_GBYTE for one byte read per result, if any.
// Reset clears state, pointers, config and strobe; not data registers or memories.
// Results cannot be stalled, so the output register never holds an item back.
module message_ring_queue_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mrq_pkg::in_item_t             in_item,
  output logic                          out_strobe,
  output mrq_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrq_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [4:0]                    cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GLEN = 2'd1;
  localparam logic [1:0] S_GBYTE = 2'd2;

  localparam int SIW = mrq_pkg::SLOT_IW;
  localparam int BIW = mrq_pkg::BYTE_IW;
  localparam int AW  = mrq_pkg::ADDR_W;
  localparam int CW  = mrq_pkg::CNT_W;
  localparam int LW  = mrq_pkg::LEN_W;

  logic [1:0]     state_r, state_nxt;
  logic [4:0]     entry_count_r, entry_count_nxt;
  logic [4:0]     entry_size_r, entry_size_nxt;
  logic [SIW-1:0] head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SIW-1:0] stg_slot_r, stg_slot_nxt;
  logic [LW-1:0]  stg_len_r, stg_len_nxt;
  logic           stg_active_r, stg_active_nxt;
  logic           stg_front_r, stg_front_nxt;
  logic [SIW-1:0] get_head_r, get_head_nxt;
  logic [LW-1:0]  get_max_r, get_max_nxt;
  logic [LW-1:0]  get_len_r, get_len_nxt;
  logic [BIW-1:0] byte_idx_r, byte_idx_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  mrq_pkg::out_item_t out_item_r, out_item_nxt;

  logic [CW-1:0]  ec;
  logic [LW-1:0]  es;
  logic [CW:0]    back_sum;
  logic [CW:0]    front_sum;
  logic [SIW-1:0] back_slot;
  logic [SIW-1:0] front_slot;
  logic [SIW-1:0] slot_cur;
  logic [LW-1:0]  len_cur;
  logic           act_cur;
  logic           front_cur;
  logic [LW-1:0]  len_pick;

  logic           byte_we;
  logic [AW-1:0]  byte_waddr;
  logic [AW-1:0]  byte_raddr;
  logic [7:0]     byte_rdata;
  logic           len_we;
  logic [SIW-1:0] len_raddr;
  logic [LW-1:0]  len_rdata;

  mrq_ram #(.DEPTH(mrq_pkg::SLOT_DEPTH * mrq_pkg::SLOT_BYTES), .WIDTH(8)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (in_item.data_byte),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  mrq_ram #(.DEPTH(mrq_pkg::SLOT_DEPTH), .WIDTH(LW)) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (stg_slot_nxt),
    .wdata (len_cur),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  always_comb begin
    if (entry_count_r == 5'd0) begin
      ec = CW'(1);
    end else if (32'(entry_count_r) > mrq_pkg::SLOT_DEPTH) begin
      ec = CW'(mrq_pkg::SLOT_DEPTH);
    end else begin
      ec = entry_count_r;
    end
    if (entry_size_r == 5'd0) begin
      es = LW'(1);
    end else if (32'(entry_size_r) > mrq_pkg::SLOT_BYTES) begin
      es = LW'(mrq_pkg::SLOT_BYTES);
    end else begin
      es = entry_size_r;
    end
  end

  always_comb begin
    back_sum  = (CW+1)'(head_r) + (CW+1)'(count_r);
    front_sum = (CW+1)'(head_r) + (CW+1)'(ec) - (CW+1)'(1);
    back_slot  = (back_sum >= (CW+1)'(ec)) ? SIW'(back_sum - (CW+1)'(ec)) : SIW'(back_sum);
    if (count_r == ec) begin
      front_slot = head_r;
    end else if (front_sum >= (CW+1)'(ec)) begin
      front_slot = SIW'(front_sum - (CW+1)'(ec));
    end else begin
      front_slot = SIW'(front_sum);
    end
  end

  always_comb begin
    len_pick = len_rdata;
    if (len_pick > get_max_r) begin
      len_pick = get_max_r;
    end
    if (32'(len_pick) > mrq_pkg::LEN_CAP) begin
      len_pick = LW'(mrq_pkg::LEN_CAP);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    entry_size_nxt  = entry_size_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    stg_slot_nxt    = stg_slot_r;
    stg_len_nxt     = stg_len_r;
    stg_active_nxt  = stg_active_r;
    stg_front_nxt   = stg_front_r;
    get_head_nxt    = get_head_r;
    get_max_nxt     = get_max_r;
    get_len_nxt     = get_len_r;
    byte_idx_nxt    = byte_idx_r;
    out_strobe_nxt  = 1'b0;
    out_item_nxt    = '0;
    out_item_nxt.out_last = 1'b1;
    act_cur   = stg_active_r;
    front_cur = stg_front_r;
    slot_cur  = stg_slot_r;
    len_cur   = stg_len_r;
    byte_we    = 1'b0;
    byte_waddr = AW'(slot_cur) * AW'(mrq_pkg::SLOT_BYTES) + AW'(len_cur);
    byte_raddr = AW'(get_head_r) * AW'(mrq_pkg::SLOT_BYTES) + AW'(byte_idx_r);
    len_we    = 1'b0;
    len_raddr = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_strobe_nxt = 1'b1;
          case (in_item.kind) inside
            mrq_pkg::KIND_PUT_BACK, mrq_pkg::KIND_PUT_FRONT: begin
              if (in_item.byte_valid) begin
                if (!act_cur) begin
                  act_cur   = 1'b1;
                  front_cur = (in_item.kind == mrq_pkg::KIND_PUT_FRONT);
                  len_cur   = '0;
                  slot_cur  = front_cur ? front_slot : back_slot;
                end
                byte_waddr = AW'(slot_cur) * AW'(mrq_pkg::SLOT_BYTES) + AW'(len_cur);
                if (len_cur < es) begin
                  byte_we = 1'b1;
                  len_cur = len_cur + LW'(1);
                end
              end
              stg_active_nxt = act_cur;
              stg_front_nxt  = front_cur;
              stg_slot_nxt   = slot_cur;
              stg_len_nxt    = len_cur;
              if (in_item.last_byte) begin
                if (!act_cur || len_cur == '0) begin
                  out_item_nxt.status = mrq_pkg::ST_INVALID;
                end else begin
                  len_we = 1'b1;
                  if (count_r == ec) begin
                    if (!front_cur) begin
                      head_nxt = ((CW+1)'(slot_cur) + (CW+1)'(1) >= (CW+1)'(ec)) ? '0 :
                                 slot_cur + SIW'(1);
                    end
                    out_item_nxt.status = mrq_pkg::ST_FULL;
                  end else begin
                    count_nxt = count_r + CW'(1);
                    if (front_cur) begin
                      head_nxt = slot_cur;
                    end
                  end
                end
                stg_active_nxt = 1'b0;
                stg_len_nxt    = '0;
              end
              out_item_nxt.not_empty = (count_nxt != '0);
            end
            mrq_pkg::KIND_GET: begin
              stg_active_nxt = 1'b0;
              stg_len_nxt    = '0;
              if (count_r == '0) begin
                out_item_nxt.status = mrq_pkg::ST_EMPTY;
              end else begin
                out_strobe_nxt = 1'b0;
                get_head_nxt   = head_r;
                get_max_nxt    = in_item.max_length;
                head_nxt  = ((CW+1)'(head_r) + (CW+1)'(1) >= (CW+1)'(ec)) ? '0 :
                            head_r + SIW'(1);
                count_nxt = count_r - CW'(1);
                state_nxt = S_GLEN;
              end
            end
            mrq_pkg::KIND_CLEAR: begin
              head_nxt       = '0;
              count_nxt      = '0;
              stg_active_nxt = 1'b0;
              stg_len_nxt    = '0;
            end
            mrq_pkg::KIND_TEST: begin
              out_item_nxt.status    = (count_r == '0) ? mrq_pkg::ST_EMPTY : mrq_pkg::ST_OK;
              out_item_nxt.not_empty = (count_r != '0);
            end
            default: begin
              out_item_nxt.not_empty = (count_r != '0);
            end
          endcase
        end
      end
      S_GLEN: begin
        get_len_nxt  = len_pick;
        byte_idx_nxt = '0;
        byte_raddr   = AW'(get_head_r) * AW'(mrq_pkg::SLOT_BYTES);
        if (len_pick == '0) begin
          out_strobe_nxt         = 1'b1;
          out_item_nxt.not_empty = (count_r != '0);
          state_nxt              = S_IDLE;
        end else begin
          state_nxt = S_GBYTE;
        end
      end
      S_GBYTE: begin
        out_strobe_nxt             = 1'b1;
        out_item_nxt.out_byte      = byte_rdata;
        out_item_nxt.out_valid     = 1'b1;
        out_item_nxt.out_last      = (LW'(byte_idx_r) + LW'(1) == get_len_r);
        out_item_nxt.copied_length = get_len_r;
        out_item_nxt.not_empty     = (count_r != '0);
        byte_idx_nxt = byte_idx_r + BIW'(1);
        byte_raddr   = AW'(get_head_r) * AW'(mrq_pkg::SLOT_BYTES) + AW'(byte_idx_nxt);
        if (out_item_nxt.out_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_index)
        mrq_pkg::CFG_ENTRY_COUNT: begin
          entry_count_nxt = cfg_data;
          head_nxt        = '0;
          count_nxt       = '0;
          stg_active_nxt  = 1'b0;
          stg_len_nxt     = '0;
        end
        mrq_pkg::CFG_ENTRY_SIZE: begin
          entry_size_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= 5'd16;
      entry_size_r  <= 5'd16;
      head_r        <= '0;
      count_r       <= '0;
      stg_slot_r    <= '0;
      stg_len_r     <= '0;
      stg_active_r  <= 1'b0;
      stg_front_r   <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      entry_size_r  <= entry_size_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      stg_slot_r    <= stg_slot_nxt;
      stg_len_r     <= stg_len_nxt;
      stg_active_r  <= stg_active_nxt;
      stg_front_r   <= stg_front_nxt;
      out_strobe_r  <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    get_head_r <= get_head_nxt;
    get_max_r  <= get_max_nxt;
    get_len_r  <= get_len_nxt;
    byte_idx_r <= byte_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// File: dv/tb.sv
// Self-checking testbench for message_ring_queue_top: a directed table, then random
// message traffic over several register settings, checked against an in-bench ring model.
// Depends on mrq_pkg and message_ring_queue_top only.
module tb;

  typedef struct {
    mrq_pkg::in_item_t it;
    bit                typed;
    logic [1:0]        st;
    logic              ne;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam int PHASE_ITEMS = 55;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  mrq_pkg::in_item_t           in_item = '0;
  logic                        out_strobe;
  mrq_pkg::out_item_t          out_item;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mrq_pkg::CFG_IW-1:0]  cfg_index = mrq_pkg::CFG_ENTRY_COUNT;
  logic [4:0]                  cfg_data = '0;

  logic [7:0]  ring_bytes [mrq_pkg::SLOT_DEPTH*mrq_pkg::SLOT_BYTES];
  int          ring_len [mrq_pkg::SLOT_DEPTH];
  int          ring_head;
  int          ring_used;
  int          fill_slot;
  int          fill_len;
  bit          fill_open;
  bit          fill_front;
  logic [4:0]  count_reg;
  logic [4:0]  size_reg;

  mrq_pkg::out_item_t step_results [$];
  mrq_pkg::out_item_t pending_results [$];
  int          mismatches = 0;
  int          phase_items;
  bit          sender_idles = 1'b1;

  bit          count_on [7] = '{1, 1, 1, 0, 1, 1, 1};
  logic [4:0]  count_val [7] = '{5'd1, 5'd0, 5'd31, 5'd0, 5'd2, 5'd16, 5'd0};
  logic [4:0]  size_val [7] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd5, 5'd0};

  dir_row_t dir_rows [N_DIR] = '{
    '{'{mrq_pkg::KIND_TEST, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_EMPTY, 1'b0},
    '{'{mrq_pkg::KIND_GET, 8'h00, 1'b0, 1'b0, 5'd16}, 1'b1, mrq_pkg::ST_EMPTY, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h00, 1'b0, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_INVALID, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'hFF, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h00, 1'b1, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'hFF, 1'b1, 1'b1, 5'd31}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_PUT_FRONT, 8'hA5, 1'b1, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_TEST, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_GET, 8'h00, 1'b0, 1'b0, 5'd31}, 1'b0, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_GET, 8'hFF, 1'b1, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{3'd5, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{3'd7, 8'hFF, 1'b1, 1'b1, 5'd31}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_FRONT, 8'h5A, 1'b1, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h3C, 1'b1, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_FRONT, 8'hC3, 1'b1, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_GET, 8'h00, 1'b0, 1'b0, 5'd1}, 1'b0, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h11, 1'b1, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_GET, 8'h00, 1'b0, 1'b0, 5'd16}, 1'b1, mrq_pkg::ST_EMPTY, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h22, 1'b1, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h33, 1'b1, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b1},
    '{'{mrq_pkg::KIND_CLEAR, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_OK, 1'b0},
    '{'{mrq_pkg::KIND_PUT_BACK, 8'h00, 1'b0, 1'b1, 5'd0}, 1'b1, mrq_pkg::ST_INVALID, 1'b0},
    '{'{mrq_pkg::KIND_TEST, 8'h00, 1'b0, 1'b0, 5'd0}, 1'b1, mrq_pkg::ST_EMPTY, 1'b0}
  };

  message_ring_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("message_ring_queue_top test failed");
    $finish;
  end

  function automatic mrq_pkg::out_item_t make_result(logic [1:0] st, logic [7:0] b, logic v,
                                                     logic last, int len);
    mrq_pkg::out_item_t r;
    r.status        = st;
    r.out_byte      = b;
    r.out_valid     = v;
    r.out_last      = last;
    r.copied_length = len[4:0];
    r.not_empty     = (ring_used != 0);
    return r;
  endfunction

  function automatic void ring_reset();
    ring_head  = 0;
    ring_used  = 0;
    fill_slot  = 0;
    fill_len   = 0;
    fill_open  = 1'b0;
    fill_front = 1'b0;
    count_reg  = 5'd16;
    size_reg   = 5'd16;
  endfunction

  function automatic void apply_reg(logic [mrq_pkg::CFG_IW-1:0] idx, logic [4:0] val);
    if (idx == mrq_pkg::CFG_ENTRY_COUNT) begin
      count_reg = val;
      ring_head = 0;
      ring_used = 0;
      fill_open = 1'b0;
      fill_len  = 0;
    end else if (idx == mrq_pkg::CFG_ENTRY_SIZE) begin
      size_reg = val;
    end
  endfunction

  function automatic void ring_step(mrq_pkg::in_item_t it);
    int ec;
    int es;
    int ln;
    int h;
    logic [1:0] st;
    step_results.delete();
    ec = (count_reg == 0) ? 1 :
         ((count_reg > mrq_pkg::SLOT_DEPTH) ? mrq_pkg::SLOT_DEPTH : int'(count_reg));
    es = (size_reg == 0) ? 1 :
         ((size_reg > mrq_pkg::SLOT_BYTES) ? mrq_pkg::SLOT_BYTES : int'(size_reg));
    if (ring_head >= ec) ring_head = 0;
    if (ring_used > ec) ring_used = ec;
    case (it.kind) inside
      mrq_pkg::KIND_PUT_BACK, mrq_pkg::KIND_PUT_FRONT: begin
        st = mrq_pkg::ST_OK;
        if (it.byte_valid) begin
          if (!fill_open) begin
            fill_open  = 1'b1;
            fill_front = (it.kind == mrq_pkg::KIND_PUT_FRONT);
            fill_len   = 0;
            if (!fill_front) fill_slot = (ring_head + ring_used) % ec;
            else if (ring_used == ec) fill_slot = ring_head;
            else fill_slot = (ring_head + ec - 1) % ec;
          end
          if (fill_len < es) begin
            ring_bytes[fill_slot*mrq_pkg::SLOT_BYTES + fill_len] = it.data_byte;
            fill_len++;
          end
        end
        if (it.last_byte) begin
          if (!fill_open || fill_len == 0) begin
            st = mrq_pkg::ST_INVALID;
          end else begin
            ring_len[fill_slot] = fill_len;
            if (ring_used == ec) begin
              if (!fill_front) ring_head = (fill_slot + 1) % ec;
              st = mrq_pkg::ST_FULL;
            end else begin
              ring_used++;
              if (fill_front) ring_head = fill_slot;
            end
          end
          fill_open = 1'b0;
          fill_len  = 0;
        end
        step_results.push_back(make_result(st, 8'h00, 1'b0, 1'b1, 0));
      end
      mrq_pkg::KIND_GET: begin
        fill_open = 1'b0;
        fill_len  = 0;
        if (ring_used == 0) begin
          step_results.push_back(make_result(mrq_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1, 0));
        end else begin
          h  = ring_head;
          ln = ring_len[h];
          if (ln > int'(it.max_length)) ln = int'(it.max_length);
          if (ln > mrq_pkg::LEN_CAP) ln = mrq_pkg::LEN_CAP;
          ring_head = (ring_head + 1) % ec;
          ring_used--;
          if (ln == 0) begin
            step_results.push_back(make_result(mrq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 0));
          end else begin
            for (int k = 0; k < ln; k++) begin
              step_results.push_back(make_result(mrq_pkg::ST_OK,
                                                 ring_bytes[h*mrq_pkg::SLOT_BYTES + k], 1'b1,
                                                 k == ln - 1, ln));
            end
          end
        end
      end
      mrq_pkg::KIND_CLEAR: begin
        ring_head = 0;
        ring_used = 0;
        fill_open = 1'b0;
        fill_len  = 0;
        step_results.push_back(make_result(mrq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 0));
      end
      mrq_pkg::KIND_TEST: begin
        step_results.push_back(make_result((ring_used == 0) ? mrq_pkg::ST_EMPTY :
                                           mrq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 0));
      end
      default: begin
        step_results.push_back(make_result(mrq_pkg::ST_OK, 8'h00, 1'b0, 1'b1, 0));
      end
    endcase
  endfunction

  function automatic mrq_pkg::in_item_t rand_item(logic [2:0] kind, logic bv, logic last);
    mrq_pkg::in_item_t it;
    it.kind       = kind;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.byte_valid = bv;
    it.last_byte  = last;
    it.max_length = 5'($urandom_range(0, 31));
    return it;
  endfunction

  task automatic send_item(mrq_pkg::in_item_t it, bit typed, mrq_pkg::out_item_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) sender_idles = !sender_idles;
    gap = sender_idles ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    ring_step(it);
    if (typed) pending_results.push_back(want);
    else foreach (step_results[i]) pending_results.push_back(step_results[i]);
    phase_items++;
  endtask

  task automatic send(mrq_pkg::in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(bit do_count, logic [4:0] cnt, logic [4:0] sz);
    cfg_valid <= 1'b1;
    if (do_count) begin
      cfg_index <= mrq_pkg::CFG_ENTRY_COUNT;
      cfg_data  <= cnt;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(mrq_pkg::CFG_ENTRY_COUNT, cnt);
    end
    cfg_index <= mrq_pkg::CFG_ENTRY_SIZE;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(mrq_pkg::CFG_ENTRY_SIZE, sz);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_message(logic [2:0] first_kind, int n, bit marker);
    mrq_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = rand_item((i == 0) ? first_kind :
                     ($urandom_range(0, 1) ? mrq_pkg::KIND_PUT_FRONT : mrq_pkg::KIND_PUT_BACK),
                     1'b1, (i == n - 1) && !marker);
      send(it);
      if (!it.last_byte && $urandom_range(0, 7) == 0) begin
        send(rand_item(mrq_pkg::KIND_PUT_BACK, 1'b0, 1'b0));
      end
    end
    if (marker || n == 0) begin
      send(rand_item($urandom_range(0, 1) ? mrq_pkg::KIND_PUT_FRONT : mrq_pkg::KIND_PUT_BACK,
                     1'b0, 1'b1));
    end
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mrq_pkg::out_item_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("out_valid", want.out_valid, out_item.out_valid);
        check_field("out_last", want.out_last, out_item.out_last);
        check_field("copied_length", want.copied_length, out_item.copied_length);
        check_field("not_empty", want.not_empty, out_item.not_empty);
      end
    end
  end

  initial begin
    mrq_pkg::out_item_t want;
    int          pick;
    int          n;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    ring_reset();
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      want = '0;
      want.status    = dir_rows[i].st;
      want.out_last  = 1'b1;
      want.not_empty = dir_rows[i].ne;
      send_item(dir_rows[i].it, dir_rows[i].typed, want);
    end

    count_val[6] = 5'($urandom_range(0, 31));
    size_val[6]  = 5'($urandom_range(0, 31));
    for (int p = 0; p < 7; p++) begin
      if ($urandom_range(0, 1)) send(rand_item(mrq_pkg::KIND_PUT_BACK, 1'b1, 1'b0));
      hold_off();
      write_cfg(count_on[p], count_val[p], size_val[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 18);
          put_message($urandom_range(0, 1) ? mrq_pkg::KIND_PUT_FRONT : mrq_pkg::KIND_PUT_BACK,
                      n, $urandom_range(0, 3) == 0);
        end else if (pick < 75) begin
          send(rand_item(mrq_pkg::KIND_GET, 1'b0, 1'b0));
        end else if (pick < 80) begin
          send(rand_item(mrq_pkg::KIND_CLEAR, 1'b0, 1'b0));
        end else if (pick < 85) begin
          send(rand_item(mrq_pkg::KIND_TEST, 1'b0, 1'b0));
        end else if (pick < 93) begin
          send(rand_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
        end else begin
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            send(rand_item($urandom_range(0, 1) ? mrq_pkg::KIND_PUT_FRONT :
                           mrq_pkg::KIND_PUT_BACK, 1'b1, 1'b0));
          end
          send(rand_item($urandom_range(0, 1) ? mrq_pkg::KIND_GET : mrq_pkg::KIND_CLEAR,
                         1'b0, 1'b0));
        end
      end
    end

    hold_off();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("message_ring_queue_top test passed");
    end else begin
      $display("message_ring_queue_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/mrq_pkg.sv
sv/mrq_ram.sv
sv/message_ring_queue_top.sv
dv/tb.sv
